### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on aclk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/dlp_pkg.sv
// ----------------------------------------------------------------------------
// dlp_pkg
// Types and character constants for the decimal line parser.
// ----------------------------------------------------------------------------
package dlp_pkg;

    localparam int VALUE_W = 32;

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_DIGIT = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       chunk_end;
        logic       message_end;
    } item_t;

    typedef struct packed {
        status_t              status;
        logic [VALUE_W-1:0]   parsed_value;
    } result_t;

endpackage

### src/dlp_acc.sv
// ----------------------------------------------------------------------------
// dlp_acc
// Parser state and per-word update: digit accumulate, overflow check,
// sticky error, CR/LF chunk skip, result formation at message end.
// ----------------------------------------------------------------------------
module dlp_acc (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  dlp_pkg::item_t    item,
    output dlp_pkg::result_t  result
);

    logic [31:0]       value_acc_reg, value_acc_next;
    dlp_pkg::status_t  pending_error_reg, pending_error_next;
    logic              char_seen_reg, char_seen_next;
    logic              skipping_reg, skipping_next;

    logic              is_crlf;
    logic              is_digit;
    logic              take;
    logic [3:0]        digit;
    logic [35:0]       scaled;
    logic              overflow;
    dlp_pkg::status_t  status;

    always_comb begin
        is_crlf  = (item.rx_byte == dlp_pkg::CHAR_CR) || (item.rx_byte == dlp_pkg::CHAR_LF);
        is_digit = (item.rx_byte >= dlp_pkg::CHAR_ZERO) && (item.rx_byte <= dlp_pkg::CHAR_NINE);
        take     = !skipping_reg && !is_crlf;
        digit    = 4'(item.rx_byte - dlp_pkg::CHAR_ZERO);
        // value * 10 + digit, wide enough to see the carry past 32 bits
        scaled   = ({4'd0, value_acc_reg} << 3) + ({4'd0, value_acc_reg} << 1)
                   + {32'd0, digit};
        overflow = (scaled[35:32] != 4'd0);

        value_acc_next     = value_acc_reg;
        pending_error_next = pending_error_reg;
        char_seen_next     = char_seen_reg;

        if (take) begin
            char_seen_next = 1'b1;
            if (pending_error_reg == dlp_pkg::ST_OK) begin
                if (!is_digit) begin
                    pending_error_next = dlp_pkg::ST_NOT_DIGIT;
                end else if (overflow) begin
                    pending_error_next = dlp_pkg::ST_OVERFLOW;
                end else begin
                    value_acc_next = scaled[31:0];
                end
            end
        end

        if (item.chunk_end || item.message_end) begin
            skipping_next = 1'b0;
        end else begin
            skipping_next = skipping_reg || (!skipping_reg && is_crlf);
        end

        status              = char_seen_next ? pending_error_next : dlp_pkg::ST_EMPTY;
        result.status       = status;
        result.parsed_value = (status == dlp_pkg::ST_OK) ? value_acc_next : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_acc_reg     <= 32'd0;
            pending_error_reg <= dlp_pkg::ST_OK;
            char_seen_reg     <= 1'b0;
            skipping_reg      <= 1'b0;
        end else if (step) begin
            if (item.message_end) begin
                value_acc_reg     <= 32'd0;
                pending_error_reg <= dlp_pkg::ST_OK;
                char_seen_reg     <= 1'b0;
                skipping_reg      <= 1'b0;
            end else begin
                value_acc_reg     <= value_acc_next;
                pending_error_reg <= pending_error_next;
                char_seen_reg     <= char_seen_next;
                skipping_reg      <= skipping_next;
            end
        end
    end

endmodule

### src/decimal_line_parser.sv
// ----------------------------------------------------------------------------
// decimal_line_parser
// On-the-fly ASCII decimal to u32 parser, one word per cycle when not stalled.
// ----------------------------------------------------------------------------
// Input channel s_*: one received character word per handshake, with
// s_chunk_end marking the last word of a receive chunk and s_message_end the
// last word of a message. A CR or LF skips the rest of its chunk.
// Result channel m_*: one word per message, m_status (0 ok, 1 empty,
// 2 non-digit, 3 overflow) and m_parsed_value (zero unless ok).
// Throughput: one input word per cycle while no message-end word is stalled.
// Each word waits in the input register, where the multiply-by-ten, add
// and range check update the parser state; the result lands in the output
// register, and m_valid rises the cycle after its message-end word advances.
// Only a message-end word needs the output register; while the receiver
// stalls with a result held, non-final words keep flowing and a second
// message-end word waits in the input register, holding s_ready low.
// Reset (aresetn low, synchronous) empties both registers and clears the
// accumulator, the sticky error and the skip flag; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module decimal_line_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_chunk_end,
    input  logic        s_message_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_parsed_value
);

    logic              in_valid_reg;
    dlp_pkg::item_t    in_item_reg;
    logic              out_valid_reg, out_valid_next;
    dlp_pkg::result_t  out_result_reg;
    dlp_pkg::result_t  step_result;
    logic              out_free;
    logic              advance;
    logic              load_out;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_item_reg.message_end || out_free);
    assign load_out = advance && in_item_reg.message_end;
    assign s_ready  = !in_valid_reg || advance;

    always_comb begin
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    dlp_acc u_acc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.rx_byte     <= s_rx_byte;
            in_item_reg.chunk_end   <= s_chunk_end;
            in_item_reg.message_end <= s_message_end;
        end
        if (load_out) begin
            out_result_reg <= step_result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = out_result_reg.status;
    assign m_parsed_value = out_result_reg.parsed_value;

    `ASSERT_NOW(a_value_zero_on_error,
        m_valid && (m_status != dlp_pkg::ST_OK), m_parsed_value == 32'd0)
    `ASSERT_NOW(a_inner_word_no_stall,
        in_valid_reg && !in_item_reg.message_end, s_ready)
    `ASSERT_NEXT(a_result_drains,
        m_valid && m_ready && !load_out, !m_valid)
    `ASSERT_NEXT(a_result_loaded,
        load_out, m_valid)

endmodule
